// ===== sv/sobel_pkg.sv =====
// shared types and constants for the sobel edge magnitude unit
// used by sobel_ctrl, sobel_datapath and sobel_edge_magnitude_unit
// no dependencies
package sobel_pkg;

    localparam int MAX_WIDTH = 2048;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int EW_W      = COL_W + 1;

    localparam int PIX_W     = 8;
    localparam int CFG_W_W   = 12;
    localparam int CFG_H_W   = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_ADDR_W = 2;
    localparam int ROW_W     = 16;

    localparam int GRAD_W    = 11;
    localparam int SQ_W      = 21;
    localparam int ROOT_W    = 16;
    localparam int RES_W     = 17;

    // floor(s / 3) = (s * 683) >> 11 for s up to 765
    localparam int SUM3_W    = 10;
    localparam int RECIP3    = 683;
    localparam int RECIP3_SH = 11;
    localparam int RECIP3_W  = 10;

    localparam logic [CFG_ADDR_W-1:0] CFG_IDX_WIDTH  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_IDX_HEIGHT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_IDX_MODE   = 2'd2;

    localparam logic [CFG_W_W-1:0] RST_WIDTH  = 12'd640;
    localparam logic [CFG_H_W-1:0] RST_HEIGHT = 16'd480;
    localparam logic               RST_MODE   = 1'b1;

    localparam logic [PIX_W-1:0] MAG_SAT = 8'd255;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WINDOW,
        S_GRAD,
        S_SQUARE,
        S_ROOT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic accept;
        logic window;
        logic grad;
        logic square;
        logic root_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic interior;
        logic root_last;
        logic out_free;
    } t_status;

endpackage

// ===== sv/sobel_edge_magnitude_unit.sv =====
// Sobel 3x3 edge magnitude over a raster pixel stream. Each pixel is reduced to gray
// (rgb average or first channel), kept in two line stores of 2048 entries, and every
// interior pixel yields floor(sqrt(gx^2+gy^2)) saturated to 255; border pixels yield
// nothing, and frame_last flags the last interior pixel. One item is worked at a time:
// a border pixel gets a line store read and window update; an interior pixel goes on
// through gradient, square sum, bit-serial square root and output load, the last waiting
// for a free output register. The line stores need no clearing after reset.
// top level: sobel_ctrl and sobel_datapath, depends on sobel_pkg
module sobel_edge_magnitude_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [sobel_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [sobel_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [sobel_pkg::PIX_W-1:0]      i_red_or_gray,
    input  logic [sobel_pkg::PIX_W-1:0]      i_green,
    input  logic [sobel_pkg::PIX_W-1:0]      i_blue,
    input  logic                             i_frame_start,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [sobel_pkg::PIX_W-1:0]      o_edge_magnitude,
    output logic                             o_frame_last
);
    import sobel_pkg::*;

    t_cmd    cmd;
    t_status status;

    sobel_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    sobel_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_addr       (i_cfg_addr),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_red_or_gray    (i_red_or_gray),
        .i_green          (i_green),
        .i_blue           (i_blue),
        .i_frame_start    (i_frame_start),
        .i_cmd            (cmd),
        .o_status         (status),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_edge_magnitude (o_edge_magnitude),
        .o_frame_last     (o_frame_last)
    );

endmodule

// ===== sv/sobel_ctrl.sv =====
// controller state machine for the sobel edge magnitude unit
// sequences read, window shift, gradient, square sum, root and output load
// depends on sobel_pkg
module sobel_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  sobel_pkg::t_status i_status,
    output sobel_pkg::t_cmd    o_cmd
);
    import sobel_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_WINDOW;
                end
            end
            S_WINDOW: begin
                o_cmd.window = 1'b1;
                n_state      = i_status.interior ? S_GRAD : S_IDLE;
            end
            S_GRAD: begin
                o_cmd.grad = 1'b1;
                n_state    = S_SQUARE;
            end
            S_SQUARE: begin
                o_cmd.square = 1'b1;
                n_state      = S_ROOT;
            end
            S_ROOT: begin
                o_cmd.root_step = 1'b1;
                if (i_status.root_last) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/sobel_datapath.sv =====
// datapath of the sobel edge magnitude unit: config registers, position counters,
// line stores, 3x3 window, gradient, square sum, bitwise root and output register
// depends on sobel_pkg
module sobel_datapath (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_wr_en,
    input  logic [sobel_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  logic [sobel_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    input  logic [sobel_pkg::PIX_W-1:0]           i_red_or_gray,
    input  logic [sobel_pkg::PIX_W-1:0]           i_green,
    input  logic [sobel_pkg::PIX_W-1:0]           i_blue,
    input  logic                                  i_frame_start,
    input  sobel_pkg::t_cmd                       i_cmd,
    output sobel_pkg::t_status                    o_status,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [sobel_pkg::PIX_W-1:0]           o_edge_magnitude,
    output logic                                  o_frame_last
);
    import sobel_pkg::*;

    // configuration
    logic [CFG_W_W-1:0] r_cfg_width;
    logic [CFG_H_W-1:0] r_cfg_height;
    logic               r_cfg_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= RST_WIDTH;
            r_cfg_height <= RST_HEIGHT;
            r_cfg_mode   <= RST_MODE;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                CFG_IDX_WIDTH:  r_cfg_width  <= i_cfg_wdata[CFG_W_W-1:0];
                CFG_IDX_HEIGHT: r_cfg_height <= i_cfg_wdata[CFG_H_W-1:0];
                CFG_IDX_MODE:   r_cfg_mode   <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    logic [EW_W-1:0]  eff_w;
    logic [ROW_W-1:0] eff_h;

    always_comb begin
        if (32'(r_cfg_width) > MAX_WIDTH) begin
            eff_w = EW_W'(MAX_WIDTH);
        end else if (r_cfg_width < CFG_W_W'(3)) begin
            eff_w = EW_W'(3);
        end else begin
            eff_w = EW_W'(r_cfg_width);
        end
        eff_h = (r_cfg_height < CFG_H_W'(3)) ? ROW_W'(3) : r_cfg_height;
    end

    // position of the incoming item
    logic [COL_W-1:0] r_col_cnt;
    logic [ROW_W-1:0] r_row_cnt;
    logic [COL_W-1:0] r_cur_col;
    logic [ROW_W-1:0] r_cur_row;
    logic [COL_W-1:0] pos_col;
    logic [ROW_W-1:0] pos_row;

    always_comb begin
        pos_col = i_frame_start ? '0 : r_col_cnt;
        pos_row = i_frame_start ? '0 : r_row_cnt;
        if (EW_W'(pos_col) >= eff_w) begin
            pos_col = '0;
        end
        if (pos_row >= eff_h) begin
            pos_row = '0;
        end
    end

    // gray conversion
    logic [SUM3_W-1:0]            rgb_sum;
    logic [SUM3_W+RECIP3_W-1:0]   rgb_prod;
    logic [PIX_W-1:0]             gray;

    always_comb begin
        rgb_sum  = SUM3_W'(i_red_or_gray) + SUM3_W'(i_green) + SUM3_W'(i_blue);
        rgb_prod = (SUM3_W+RECIP3_W)'(rgb_sum) * (SUM3_W+RECIP3_W)'(RECIP3);
        gray     = r_cfg_mode ? rgb_prod[RECIP3_SH +: PIX_W] : i_red_or_gray;
    end

    logic [PIX_W-1:0] r_gray;
    logic             r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_cnt <= '0;
            r_row_cnt <= '0;
        end else if (i_cmd.window) begin
            if (EW_W'(r_cur_col) >= eff_w - EW_W'(1)) begin
                r_col_cnt <= '0;
                r_row_cnt <= (r_cur_row >= eff_h - ROW_W'(1)) ? '0 : r_cur_row + ROW_W'(1);
            end else begin
                r_col_cnt <= r_cur_col + COL_W'(1);
                r_row_cnt <= r_cur_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cur_col <= pos_col;
            r_cur_row <= pos_row;
            r_gray    <= gray;
            r_last    <= (pos_row == eff_h - ROW_W'(1)) &&
                         (EW_W'(pos_col) == eff_w - EW_W'(1));
        end
    end

    assign o_status.interior = (r_cur_row >= ROW_W'(2)) && (r_cur_col >= COL_W'(2));

    // line stores
    logic [PIX_W-1:0] mem_upper  [MAX_WIDTH];
    logic [PIX_W-1:0] mem_middle [MAX_WIDTH];
    logic [PIX_W-1:0] r_upper_rd;
    logic [PIX_W-1:0] r_middle_rd;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_upper_rd  <= mem_upper[pos_col];
            r_middle_rd <= mem_middle[pos_col];
        end
        if (i_cmd.window) begin
            mem_upper[r_cur_col]  <= r_middle_rd;
            mem_middle[r_cur_col] <= r_gray;
        end
    end

    // 3x3 window, column 2 is the newest
    logic [PIX_W-1:0] r_win [3][3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[i][j] <= '0;
                end
            end
        end else if (i_cmd.window) begin
            for (int i = 0; i < 3; i++) begin
                r_win[i][0] <= r_win[i][1];
                r_win[i][1] <= r_win[i][2];
            end
            r_win[0][2] <= r_upper_rd;
            r_win[1][2] <= r_middle_rd;
            r_win[2][2] <= r_gray;
        end
    end

    // gradients
    logic signed [GRAD_W-1:0] r_gx;
    logic signed [GRAD_W-1:0] r_gy;
    logic        [GRAD_W-1:0] gx_pos, gx_neg, gy_pos, gy_neg;

    always_comb begin
        gx_pos = GRAD_W'(r_win[0][2]) + (GRAD_W'(r_win[1][2]) << 1) + GRAD_W'(r_win[2][2]);
        gx_neg = GRAD_W'(r_win[0][0]) + (GRAD_W'(r_win[1][0]) << 1) + GRAD_W'(r_win[2][0]);
        gy_pos = GRAD_W'(r_win[0][0]) + (GRAD_W'(r_win[0][1]) << 1) + GRAD_W'(r_win[0][2]);
        gy_neg = GRAD_W'(r_win[2][0]) + (GRAD_W'(r_win[2][1]) << 1) + GRAD_W'(r_win[2][2]);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.grad) begin
            r_gx <= signed'(gx_pos - gx_neg);
            r_gy <= signed'(gy_pos - gy_neg);
        end
    end

    // square sum and bitwise integer root
    logic signed [2*GRAD_W-1:0] gx_sq, gy_sq;
    logic        [SQ_W-1:0]     sq_sum;

    always_comb begin
        gx_sq  = (2*GRAD_W)'(r_gx) * (2*GRAD_W)'(r_gx);
        gy_sq  = (2*GRAD_W)'(r_gy) * (2*GRAD_W)'(r_gy);
        sq_sum = SQ_W'(unsigned'(gx_sq)) + SQ_W'(unsigned'(gy_sq));
    end

    logic [ROOT_W-1:0] r_rem;
    logic [RES_W-1:0]  r_res;
    logic [ROOT_W-1:0] r_bit;
    logic              r_sat;
    logic [RES_W-1:0]  trial;

    assign trial              = r_res + RES_W'(r_bit);
    assign o_status.root_last = (r_bit == ROOT_W'(1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.square) begin
            // a sum of 2^16 or more has a root above 255
            r_sat <= |sq_sum[SQ_W-1:ROOT_W];
            r_rem <= sq_sum[ROOT_W-1:0];
            r_res <= '0;
            r_bit <= ROOT_W'(1) << (ROOT_W - 2);
        end else if (i_cmd.root_step) begin
            if (RES_W'(r_rem) >= trial) begin
                r_rem <= r_rem - ROOT_W'(trial);
                r_res <= (r_res >> 1) + RES_W'(r_bit);
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    // output register
    logic             r_out_valid;
    logic [PIX_W-1:0] r_out_mag;
    logic             r_out_last;

    assign o_status.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_mag  <= (r_sat || (|r_res[RES_W-1:PIX_W])) ? MAG_SAT : r_res[PIX_W-1:0];
            r_out_last <= r_last;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_edge_magnitude = r_out_mag;
    assign o_frame_last     = r_out_last;

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// testbench for sobel_edge_magnitude_unit: a directed table of small frames, then random
// frames over many register settings, each result checked against a fixed table value or an in-bench predictor
// depends on sobel_pkg and sobel_edge_magnitude_unit
module tb_top;
    import sobel_pkg::*;

    localparam int CLK_HALF       = 4;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 30;
    localparam int MAX_REPORTS    = 10;
    localparam int N_PROBES       = 27;
    localparam int N_PHASES       = 11;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;
    typedef enum int {TEX_NOISE, TEX_FAINT, TEX_BINARY, TEX_RAMP} t_texture;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic             start;
        logic             fixed;
        logic [PIX_W-1:0] mag;
        logic             last;
    } t_probe_pixel;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] width;
        logic [CFG_DATA_W-1:0] height;
        logic [CFG_DATA_W-1:0] mode;
        t_idle_mode            idle;
        int                    n_items;
        logic                  start_first;
        logic                  restarts;
        int                    drain_at;
    } t_phase;

    typedef struct packed {
        logic [PIX_W-1:0] mag;
        logic             last;
    } t_edge_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_wr_en;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [PIX_W-1:0]      i_red_or_gray;
    logic [PIX_W-1:0]      i_green;
    logic [PIX_W-1:0]      i_blue;
    logic                  i_frame_start;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [PIX_W-1:0]      o_edge_magnitude;
    logic                  o_frame_last;

    // predictor state
    logic [CFG_W_W-1:0] mdl_width  = RST_WIDTH;
    logic [CFG_H_W-1:0] mdl_height = RST_HEIGHT;
    logic               mdl_mode   = RST_MODE;
    bit [PIX_W-1:0]     gray_upper [MAX_WIDTH];
    bit [PIX_W-1:0]     gray_middle [MAX_WIDTH];
    int                 win [3][3];
    int unsigned        col_pos = 0;
    int unsigned        row_pos = 0;

    t_edge_result       edge_q [$];
    int                 mismatches = 0;
    int                 quiet_cycles = 0;
    int                 send_idle_pct = 0;
    int                 recv_stall_pct = 0;
    logic               fixed_valid = 1'b0;
    logic [PIX_W-1:0]   fixed_mag = '0;
    logic               fixed_last = 1'b0;

    t_probe_pixel probe_tab [N_PROBES] = '{
        '{8'd0,   8'd255, 8'd255, 1'b1, 1'b0, 8'd0,   1'b0},
        '{8'd0,   8'd255, 8'd255, 1'b0, 1'b0, 8'd0,   1'b0},
        '{8'd0,   8'd255, 8'd255, 1'b0, 1'b0, 8'd0,   1'b0},
        '{8'd0,   8'd255, 8'd255, 1'b0, 1'b0, 8'd0,   1'b0},
        '{8'd0,   8'd255, 8'd255, 1'b0, 1'b0, 8'd0,   1'b0},
        '{8'd0,   8'd255, 8'd255, 1'b0, 1'b0, 8'd0,   1'b0},
        '{8'd255, 8'd0,   8'd0,   1'b0, 1'b0, 8'd0,   1'b0},
        '{8'd255, 8'd0,   8'd0,   1'b0, 1'b0, 8'd0,   1'b0},
        '{8'd255, 8'd0,   8'd0,   1'b0, 1'b1, 8'd255, 1'b1},
        // next frame follows without a frame start
        '{8'd255, 8'd0,   8'd0,   1'b0, 1'b0, 8'd0,   1'b0},
        '{8'd255, 8'd0,   8'd0,   1'b0, 1'b0, 8'd0,   1'b0},
        '{8'd255, 8'd0,   8'd0,   1'b0, 1'b0, 8'd0,   1'b0},
        '{8'd255, 8'd0,   8'd0,   1'b0, 1'b0, 8'd0,   1'b0},
        '{8'd255, 8'd0,   8'd0,   1'b0, 1'b0, 8'd0,   1'b0},
        '{8'd255, 8'd0,   8'd0,   1'b0, 1'b0, 8'd0,   1'b0},
        '{8'd255, 8'd0,   8'd0,   1'b0, 1'b0, 8'd0,   1'b0},
        '{8'd255, 8'd0,   8'd0,   1'b0, 1'b0, 8'd0,   1'b0},
        '{8'd255, 8'd0,   8'd0,   1'b0, 1'b1, 8'd0,   1'b1},
        // rgb mode from here on
        '{8'd3,   8'd3,   8'd3,   1'b1, 1'b0, 8'd0,   1'b0},
        '{8'd3,   8'd3,   8'd3,   1'b0, 1'b0, 8'd0,   1'b0},
        '{8'd3,   8'd3,   8'd3,   1'b0, 1'b0, 8'd0,   1'b0},
        '{8'd255, 8'd0,   8'd0,   1'b0, 1'b0, 8'd0,   1'b0},
        '{8'd255, 8'd0,   8'd0,   1'b0, 1'b0, 8'd0,   1'b0},
        '{8'd255, 8'd0,   8'd0,   1'b0, 1'b0, 8'd0,   1'b0},
        '{8'd1,   8'd1,   8'd0,   1'b0, 1'b0, 8'd0,   1'b0},
        '{8'd1,   8'd1,   8'd0,   1'b0, 1'b0, 8'd0,   1'b0},
        '{8'd1,   8'd1,   8'd0,   1'b0, 1'b1, 8'd12,  1'b1}
    };

    t_phase plan [N_PHASES];

    sobel_edge_magnitude_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_addr       (i_cfg_addr),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_red_or_gray    (i_red_or_gray),
        .i_green          (i_green),
        .i_blue           (i_blue),
        .i_frame_start    (i_frame_start),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_edge_magnitude (o_edge_magnitude),
        .o_frame_last     (o_frame_last)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    task predict_pixel(input logic [PIX_W-1:0] r, g, b, input logic fs,
                       output logic hit, output logic [PIX_W-1:0] mag, output logic last);
        int unsigned w, h, sq, root;
        int          gray, gx, gy;
        begin
            w = (mdl_width < 3) ? 3 : ((mdl_width > MAX_WIDTH) ? MAX_WIDTH : int'(mdl_width));
            h = (mdl_height < 3) ? 3 : int'(mdl_height);
            if (fs) begin
                col_pos = 0;
                row_pos = 0;
            end
            if (col_pos >= w) col_pos = 0;
            if (row_pos >= h) row_pos = 0;
            gray = mdl_mode ? (int'(r) + int'(g) + int'(b)) / 3 : int'(r);
            for (int i = 0; i < 3; i++) begin
                win[i][0] = win[i][1];
                win[i][1] = win[i][2];
            end
            win[0][2] = gray_upper[col_pos];
            win[1][2] = gray_middle[col_pos];
            win[2][2] = gray;
            gray_upper[col_pos]  = gray_middle[col_pos];
            gray_middle[col_pos] = 8'(gray);
            hit = (row_pos >= 2) && (col_pos >= 2);
            gx = (win[0][2] + 2 * win[1][2] + win[2][2]) - (win[0][0] + 2 * win[1][0] + win[2][0]);
            gy = (win[0][0] + 2 * win[0][1] + win[0][2]) - (win[2][0] + 2 * win[2][1] + win[2][2]);
            sq = gx * gx + gy * gy;
            root = 0;
            while (root < 255 && (root + 1) * (root + 1) <= sq) root++;
            mag = 8'(root);
            last = (row_pos == h - 1) && (col_pos == w - 1);
            if (col_pos >= w - 1) begin
                col_pos = 0;
                row_pos = (row_pos >= h - 1) ? 0 : row_pos + 1;
            end else begin
                col_pos++;
            end
        end
    endtask

    task note_mismatch(input string what, input logic [PIX_W-1:0] want, got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch on %s at %0t: expected %0d, got %0d", what, $realtime, want, got);
    endtask

    always @(posedge i_clk) begin
        logic             hit;
        logic [PIX_W-1:0] mag;
        logic             last;
        t_edge_result     want;
        if (i_rst_n) begin
            if (i_cfg_wr_en) begin
                case (i_cfg_addr)
                    CFG_IDX_WIDTH:  mdl_width  = i_cfg_wdata[CFG_W_W-1:0];
                    CFG_IDX_HEIGHT: mdl_height = i_cfg_wdata[CFG_H_W-1:0];
                    CFG_IDX_MODE:   mdl_mode   = i_cfg_wdata[0];
                    default: ;
                endcase
            end
            if (i_in_valid && o_in_ready) begin
                predict_pixel(i_red_or_gray, i_green, i_blue, i_frame_start, hit, mag, last);
                if (fixed_valid)
                    edge_q.push_back('{fixed_mag, fixed_last});
                else if (hit)
                    edge_q.push_back('{mag, last});
            end
            if (o_out_valid && i_out_ready) begin
                if (edge_q.size() == 0) begin
                    note_mismatch("unexpected item", '0, o_edge_magnitude);
                end else begin
                    want = edge_q.pop_front();
                    if (o_edge_magnitude !== want.mag)
                        note_mismatch("edge_magnitude", want.mag, o_edge_magnitude);
                    if (o_frame_last !== want.last)
                        note_mismatch("frame_last", 8'(want.last), 8'(o_frame_last));
                end
            end
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic logic [PIX_W-1:0] make_channel(t_texture tex, int base, int unsigned col);
        case (tex)
            TEX_FAINT:  return 8'(base + $urandom_range(15));
            TEX_BINARY: return $urandom_range(1) ? 8'hFF : 8'h00;
            TEX_RAMP:   return 8'(col * (base % 8 + 1) + $urandom_range(3));
            default:    return 8'($urandom_range(255));
        endcase
    endfunction

    task send_pixel(input logic [PIX_W-1:0] r, g, b, input logic fs);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_red_or_gray <= r;
        i_green       <= g;
        i_blue        <= b;
        i_frame_start <= fs;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    task wait_drained();
        i_in_valid <= 1'b0;
        while (edge_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task program_regs(input logic [CFG_DATA_W-1:0] w, h, m);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= CFG_IDX_WIDTH;
        i_cfg_wdata <= w;
        @(negedge i_clk);
        i_cfg_addr  <= CFG_IDX_HEIGHT;
        i_cfg_wdata <= h;
        @(negedge i_clk);
        i_cfg_addr  <= CFG_IDX_MODE;
        i_cfg_wdata <= m;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task run_phase(input t_phase ph);
        logic             fs;
        t_texture         tex;
        int               base;
        logic [PIX_W-1:0] r, g, b;
        begin
            wait_drained();
            program_regs(ph.width, ph.height, ph.mode);
            case (ph.idle)
                IDLE_SEND: begin send_idle_pct = 50; recv_stall_pct = 0;  end
                IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 50; end
                IDLE_BOTH: begin send_idle_pct = 31; recv_stall_pct = 31; end
                default:   begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            endcase
            tex  = t_texture'($urandom_range(3));
            base = $urandom_range(240);
            for (int n = 0; n < ph.n_items; n++) begin
                if (n == ph.drain_at) wait_drained();
                if (col_pos == 0) begin
                    tex  = t_texture'($urandom_range(3));
                    base = $urandom_range(240);
                end
                if (n == 0)
                    fs = ph.start_first;
                else if (col_pos == 0 && row_pos == 0)
                    fs = 1'($urandom_range(1));
                else
                    fs = ph.restarts && ($urandom_range(199) == 0);
                r = make_channel(tex, base, col_pos);
                g = make_channel(tex, base, col_pos);
                b = make_channel(tex, base, col_pos);
                send_pixel(r, g, b, fs);
            end
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_addr    = CFG_IDX_WIDTH;
        i_cfg_wdata   = '0;
        i_in_valid    = 1'b0;
        i_red_or_gray = '0;
        i_green       = '0;
        i_blue        = '0;
        i_frame_start = 1'b0;
        i_out_ready   = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // 3x3 frames, gray first
        program_regs(16'd3, 16'd3, 16'd0);
        for (int i = 0; i < N_PROBES; i++) begin
            if (i == 18) begin
                wait_drained();
                program_regs(16'd3, 16'd3, 16'd1);
            end
            fixed_valid = probe_tab[i].fixed;
            fixed_mag   = probe_tab[i].mag;
            fixed_last  = probe_tab[i].last;
            send_pixel(probe_tab[i].red, probe_tab[i].green, probe_tab[i].blue,
                       probe_tab[i].start);
        end
        fixed_valid = 1'b0;

        plan[0]  = '{16'd0,     16'd2,     16'd1,     IDLE_NONE, 30,  1'b1, 1'b1, -1};
        plan[1]  = '{16'd5,     16'd4,     16'd0,     IDLE_SEND, 40,  1'b1, 1'b1, -1};
        plan[2]  = '{16'd1,     16'd0,     16'hFFFE,  IDLE_RECV, 30,  1'b1, 1'b1, -1};
        plan[3]  = '{16'd7,     16'd5,     16'd1,     IDLE_BOTH, 45,  1'b1, 1'b1, 33};
        plan[4]  = '{16'd10,    16'd6,     16'd0,     IDLE_NONE, 87,  1'b1, 1'b1, -1};
        // narrower and shorter frame picked up mid-frame, counters wrap
        plan[5]  = '{16'd4,     16'd3,     16'd0,     IDLE_RECV, 40,  1'b0, 1'b1, -1};
        plan[6]  = '{16'd4,     16'hFFFF,  16'd1,     IDLE_SEND, 30,  1'b1, 1'b1, -1};
        plan[7]  = '{16'hFFFF,  16'd3,     16'd1,     IDLE_BOTH, 20,  1'b1, 1'b0, -1};
        plan[8]  = '{16'd3,     16'd3,     16'd0,     IDLE_BOTH, 30,  1'b1, 1'b1, -1};
        for (int p = 9; p < N_PHASES; p++)
            plan[p] = '{16'($urandom_range(12, 3)), 16'($urandom_range(8, 3)),
                        16'($urandom_range(1)), t_idle_mode'($urandom_range(3)),
                        40, 1'b1, 1'b1, -1};

        for (int p = 0; p < N_PHASES; p++)
            run_phase(plan[p]);

        wait_drained();
        if (mismatches == 0 && edge_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== files.f =====
sv/sobel_pkg.sv
sv/sobel_ctrl.sv
sv/sobel_datapath.sv
sv/sobel_edge_magnitude_unit.sv
bench/tb_top.sv
